// ----- hw/rtl/psc_pkg.sv -----
package psc_pkg;

	// Fixed field widths
	localparam int COS_W     = 16;
	localparam int MIN_LEN_W = 12;
	localparam int PAIR_W    = 10;
	localparam int CFG_IDX_W = 2;
	localparam int DIV_STEPS = 16;

	// Register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_MAX_COS_THR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_AVG_COS_THR = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_EDGE_LEN = 2'd2;

	// Register reset values
	localparam logic signed [COS_W-1:0]   MAX_COS_THR_RST = 16'sd16384;
	localparam logic signed [COS_W-1:0]   AVG_COS_THR_RST = 16'sd31651;
	localparam logic [MIN_LEN_W-1:0]      MIN_EDGE_LEN_RST = 12'd1;

	// Cosine limits in Q1.15
	localparam logic signed [COS_W-1:0] COS_MAX = 16'sh7FFF;
	localparam logic signed [COS_W-1:0] COS_MIN = 16'sh8000;

endpackage

// ----- hw/rtl/psc_mul.sv -----
module psc_mul #(
	parameter int MW = 27
) (
	input  logic                   clk,
	input  logic signed [MW-1:0]   a,
	input  logic signed [MW-1:0]   b,
	output logic signed [2*MW-1:0] p
);

	logic signed [2*MW-1:0] p_q;

	// registered product, available in the cycle after the operands
	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

	assign p = p_q;

endmodule

// ----- hw/rtl/psc_sqrt.sv -----
module psc_sqrt #(
	parameter int RW = 26
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [2*RW-1:0] radicand,
	output logic            done,
	output logic [RW-1:0]   root
);

	localparam int CNT_W = $clog2(RW + 1);

	logic [2*RW-1:0] rad_q;
	logic [RW:0]     rem_q;
	logic [RW-1:0]   root_q;
	logic [CNT_W-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [RW+2:0]   rem_n;
	logic [RW+2:0]   trial;
	logic            fits;

	// one result bit per cycle: bring down two radicand bits, try 4*root+1
	assign rem_n = {rem_q, rad_q[2*RW-1 -: 2]};
	assign trial = {1'b0, root_q, 2'b01};
	assign fits  = (rem_n >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(RW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= rad_q << 2;
			if (fits) begin
				rem_q  <= (RW+1)'(rem_n - trial);
				root_q <= {root_q[RW-2:0], 1'b1};
			end else begin
				rem_q  <= rem_n[RW:0];
				root_q <= {root_q[RW-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// ----- hw/rtl/polyline_straightness_check_unit.sv -----
// Sequencing: an edge runs the squares and the root, then for a later edge the dot product,
//   the length product and the divide (skipped if the cosine saturates or the length product
//   is zero), then the pair update; RW = min(COORD_WIDTH, 24) + 2, 26 by default.
// The next edge is taken only back in S_IDLE, after a last edge also the bound check and any
//   wait on out_ready; shared multiplier, one-bit-a-cycle root, 16-step divide.
// Reset: arst_n clears the chain state and loads the register defaults at once.
module polyline_straightness_check_unit #(
	parameter int COORD_WIDTH = 24,
	parameter int FRAC_BITS   = 12,
	parameter int MAX_CHAIN   = 1024
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// edge transactions
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic signed [COORD_WIDTH-1:0]          start_x,
	input  logic signed [COORD_WIDTH-1:0]          start_y,
	input  logic signed [COORD_WIDTH-1:0]          start_z,
	input  logic signed [COORD_WIDTH-1:0]          end_x,
	input  logic signed [COORD_WIDTH-1:0]          end_y,
	input  logic signed [COORD_WIDTH-1:0]          end_z,
	input  logic                                   last_edge,
	// chain result transactions
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic                                   is_distorted,
	output logic signed [psc_pkg::COS_W-1:0]       max_cosine,
	output logic [psc_pkg::PAIR_W-1:0]             pair_count,
	// register writes
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [psc_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [psc_pkg::COS_W-1:0]              cfg_data
);

	import psc_pkg::*;

	// Wide coordinates are pre-scaled so that a vector component stays within 25 bits.
	localparam int PRE_SHIFT = (COORD_WIDTH > 24) ? COORD_WIDTH - 24 : 0;
	localparam int VW  = COORD_WIDTH + 1 - PRE_SHIFT;        // vector component
	localparam int RW  = VW + 1;                             // square root of |v|^2
	localparam int LW  = (RW > FRAC_BITS + 1) ? RW : FRAC_BITS + 1; // edge length
	localparam int AW  = 2 * VW + 3;                         // dot or squared length
	localparam int CW  = 2 * LW + 2;                         // divider remainder
	localparam int CNT_W = (MAX_CHAIN > 2) ? $clog2(MAX_CHAIN) : 1;
	localparam int SUM_W = COS_W + CNT_W;
	localparam int MW0 = (LW + 1 > COS_W + 1) ? LW + 1 : COS_W + 1;
	localparam int MW  = (MW0 > CNT_W + 1) ? MW0 : CNT_W + 1;
	localparam int PW  = 2 * MW;
	localparam int LTW = LW + PRE_SHIFT + MIN_LEN_W;
	localparam int ONE_RAW = (1 << FRAC_BITS) >> PRE_SHIFT;
	localparam int ONE_I   = (ONE_RAW == 0) ? 1 : ONE_RAW;
	localparam logic [LW-1:0]    ONE_LEN = LW'(ONE_I);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_CHAIN - 1);

	typedef enum logic [3:0] {
		S_IDLE, S_SQ, S_SQRT, S_DOT, S_DEN, S_DENW, S_DIV, S_PAIR, S_UPD, S_BND,
		S_BNDW, S_FIN
	} state_t;

	state_t state_q;

	// configuration registers
	logic signed [COS_W-1:0]   max_thr_q;
	logic signed [COS_W-1:0]   avg_thr_q;
	logic [MIN_LEN_W-1:0]      min_len_q;

	// chain state; lengths are kept as raw roots, the floor is applied per pair
	logic signed [VW-1:0]      prev_q [3];
	logic [LW-1:0]             prev_len_q;
	logic                      have_prev_q;
	logic signed [COS_W-1:0]   max_q;
	logic signed [SUM_W-1:0]   sum_q;
	logic [CNT_W-1:0]          cnt_q;

	// current edge work registers
	logic signed [VW-1:0]      vec_q [3];
	logic                      last_q;
	logic [LW-1:0]             cur_len_q;
	logic signed [AW-1:0]      acc_q;
	logic signed [AW-1:0]      dot_q;
	logic [2*LW-1:0]           den_q;
	logic [CW-1:0]             rem_q;
	logic [DIV_STEPS-1:0]      frac_q;
	logic                      neg_q;
	logic signed [COS_W-1:0]   cos_q;
	logic [4:0]                k_q;
	logic                      dist_q;

	// output register
	logic                      out_valid_q;
	logic                      is_distorted_q;
	logic signed [COS_W-1:0]   max_cosine_q;
	logic [PAIR_W-1:0]         pair_count_q;

	// shared units
	logic signed [MW-1:0]      mul_a;
	logic signed [MW-1:0]      mul_b;
	logic signed [PW-1:0]      prod;
	logic                      sqrt_start;
	logic                      sqrt_done;
	logic [RW-1:0]             sqrt_root;

	logic [1:0]                sel;
	logic signed [AW-1:0]      acc_sum;
	logic signed [COORD_WIDTH:0] dx, dy, dz;
	logic [LW-1:0]             prev_len_eff;
	logic [LW-1:0]             cur_len_eff;
	logic [CW-1:0]             rem_dbl;
	logic                      rem_ge;
	logic [DIV_STEPS-1:0]      frac_n;
	logic [DIV_STEPS:0]        rnd;
	logic [CW-1:0]             mag;
	logic [31:0]               cnt_wide;
	logic                      in_acc;
	logic                      out_free;
	logic                      res_fire;

	assign in_ready  = (state_q == S_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || out_ready;
	assign res_fire  = (state_q == S_FIN) && out_free;

	// edge vector, floor-scaled for wide coordinates
	assign dx = ((COORD_WIDTH+1)'(end_x) - (COORD_WIDTH+1)'(start_x)) >>> PRE_SHIFT;
	assign dy = ((COORD_WIDTH+1)'(end_y) - (COORD_WIDTH+1)'(start_y)) >>> PRE_SHIFT;
	assign dz = ((COORD_WIDTH+1)'(end_z) - (COORD_WIDTH+1)'(start_z)) >>> PRE_SHIFT;

	// component pointer for the three multiply-accumulate issues
	assign sel     = (k_q[1:0] == 2'd3) ? 2'd2 : k_q[1:0];
	assign acc_sum = acc_q + AW'(prod);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_SQ: begin
				mul_a = MW'(vec_q[sel]);
				mul_b = MW'(vec_q[sel]);
			end
			S_DOT: begin
				mul_a = MW'(prev_q[sel]);
				mul_b = MW'(vec_q[sel]);
			end
			S_DEN: begin
				mul_a = signed'(MW'(prev_len_eff));
				mul_b = signed'(MW'(cur_len_eff));
			end
			S_BND: begin
				mul_a = MW'(avg_thr_q);
				mul_b = signed'(MW'(cnt_q));
			end
			default: begin
			end
		endcase
	end

	psc_mul #(.MW(MW)) u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	assign sqrt_start = (state_q == S_SQ) && (k_q == 5'd3);

	psc_sqrt #(.RW(RW)) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand ((2*RW)'(acc_sum)),
		.done     (sqrt_done),
		.root     (sqrt_root)
	);

	// short edges count as unit length, judged against the current floor
	assign prev_len_eff = ((LTW'(prev_len_q) << PRE_SHIFT) < LTW'(min_len_q)) ? ONE_LEN
	                                                                          : prev_len_q;
	assign cur_len_eff  = ((LTW'(cur_len_q) << PRE_SHIFT) < LTW'(min_len_q)) ? ONE_LEN
	                                                                         : cur_len_q;

	// restoring divide step on the fraction bits
	assign rem_dbl = {rem_q[CW-2:0], 1'b0};
	assign rem_ge  = (rem_dbl >= CW'(den_q));
	assign frac_n  = {frac_q[DIV_STEPS-2:0], rem_ge};
	assign rnd     = ({1'b0, frac_n} + (DIV_STEPS+1)'(1)) >> 1;

	assign mag      = (dot_q < 0) ? CW'(-dot_q) : CW'(dot_q);
	assign cnt_wide = 32'(cnt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_thr_q <= MAX_COS_THR_RST;
			avg_thr_q <= AVG_COS_THR_RST;
			min_len_q <= MIN_EDGE_LEN_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MAX_COS_THR:  max_thr_q <= signed'(cfg_data);
				REG_AVG_COS_THR:  avg_thr_q <= signed'(cfg_data);
				REG_MIN_EDGE_LEN: min_len_q <= cfg_data[MIN_LEN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			have_prev_q  <= 1'b0;
			max_q        <= COS_MIN;
			sum_q        <= '0;
			cnt_q        <= '0;
			prev_len_q   <= '0;
			for (int i = 0; i < 3; i++) begin
				prev_q[i] <= '0;
			end
			out_valid_q  <= 1'b0;
			k_q          <= '0;
			last_q       <= 1'b0;
		end else begin
			// raise a new result or drop the one just taken
			if (res_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						vec_q[0] <= dx[VW-1:0];
						vec_q[1] <= dy[VW-1:0];
						vec_q[2] <= dz[VW-1:0];
						last_q   <= last_edge;
						acc_q    <= '0;
						k_q      <= '0;
						state_q  <= S_SQ;
					end
				end
				S_SQ: begin
					// issue x, y, z squares; add each product in the cycle after it is issued
					if (k_q != 5'd0) begin
						acc_q <= acc_sum;
					end
					k_q <= k_q + 5'd1;
					if (k_q == 5'd3) begin
						state_q <= S_SQRT;
					end
				end
				S_SQRT: begin
					if (sqrt_done) begin
						cur_len_q <= LW'(sqrt_root);
						acc_q     <= '0;
						k_q       <= '0;
						state_q   <= have_prev_q ? S_DOT : S_UPD;
					end
				end
				S_DOT: begin
					if (k_q != 5'd0) begin
						acc_q <= acc_sum;
					end
					k_q <= k_q + 5'd1;
					if (k_q == 5'd3) begin
						dot_q   <= acc_sum;
						state_q <= S_DEN;
					end
				end
				S_DEN: begin
					state_q <= S_DENW;
				end
				S_DENW: begin
					den_q  <= prod[2*LW-1:0];
					rem_q  <= mag;
					neg_q  <= (dot_q < 0);
					frac_q <= '0;
					k_q    <= '0;
					if (prod[2*LW-1:0] == '0) begin
						cos_q   <= '0;
						state_q <= S_PAIR;
					end else if (mag >= CW'(prod[2*LW-1:0])) begin
						// whole part of one or more saturates
						cos_q   <= (dot_q < 0) ? COS_MIN : COS_MAX;
						state_q <= S_PAIR;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					rem_q  <= rem_ge ? rem_dbl - CW'(den_q) : rem_dbl;
					frac_q <= frac_n;
					k_q    <= k_q + 5'd1;
					if (k_q == 5'(DIV_STEPS - 1)) begin
						if (neg_q) begin
							cos_q <= COS_W'(-signed'({1'b0, rnd}));
						end else begin
							cos_q <= rnd[COS_W-1] ? COS_MAX : signed'(rnd[COS_W-1:0]);
						end
						state_q <= S_PAIR;
					end
				end
				S_PAIR: begin
					if (cos_q > max_q) begin
						max_q <= cos_q;
					end
					// past the saturation count only the maximum moves
					if (cnt_q < CNT_MAX) begin
						sum_q <= sum_q + SUM_W'(cos_q);
						cnt_q <= cnt_q + 1'b1;
					end
					state_q <= S_UPD;
				end
				S_UPD: begin
					prev_q      <= vec_q;
					prev_len_q  <= cur_len_q;
					have_prev_q <= 1'b1;
					state_q     <= last_q ? S_BND : S_IDLE;
				end
				S_BND: begin
					state_q <= S_BNDW;
				end
				S_BNDW: begin
					dist_q  <= (cnt_q != '0) &&
					           ((max_q < max_thr_q) || (PW'(sum_q) < prod));
					state_q <= S_FIN;
				end
				S_FIN: begin
					// hold until the previous result has been taken
					if (out_free) begin
						is_distorted_q <= dist_q;
						max_cosine_q   <= max_q;
						pair_count_q   <= cnt_wide[PAIR_W-1:0];
						have_prev_q    <= 1'b0;
						max_q          <= COS_MIN;
						sum_q          <= '0;
						cnt_q          <= '0;
						prev_len_q     <= '0;
						for (int i = 0; i < 3; i++) begin
							prev_q[i] <= '0;
						end
						state_q        <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign is_distorted = is_distorted_q;
	assign max_cosine   = max_cosine_q;
	assign pair_count   = pair_count_q;

	// pair count never passes its saturation point
	a_cnt_sat: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_MAX)
		else $error("pair count beyond saturation");

	// counted pairs only exist inside a chain with a previous edge
	a_cnt_prev: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != '0) |-> have_prev_q)
		else $error("pairs without a previous edge");

	// a new result clears the chain state
	a_res_clear: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> (!have_prev_q && cnt_q == '0 && max_q == COS_MIN))
		else $error("chain state not cleared on result");

	// an accepted edge closes the input until the sequencer returns
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ready)
		else $error("input open while an edge is in work");

endmodule

// ----- tb/polyline_straightness_check_unit_tb.sv -----
`timescale 1ns / 100ps

module polyline_straightness_check_unit_tb;
	import psc_pkg::*;

	localparam int CW = 24;
	localparam int FB = 12;
	localparam int CHAIN_LIMIT = 1024;
	// Settle time after the last chain result before a register write or the end
	localparam int SETTLE_CYCLES = 120;

	typedef struct {
		logic signed [CW-1:0] sx, sy, sz, ex, ey, ez;
		logic last;
	} edge_item_t;

	typedef struct {
		logic distorted;
		logic signed [COS_W-1:0] max_cos;
		logic [PAIR_W-1:0] pairs;
	} chain_verdict_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [CW-1:0] start_x = '0, start_y = '0, start_z = '0;
	logic signed [CW-1:0] end_x = '0, end_y = '0, end_z = '0;
	logic last_edge = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic is_distorted;
	logic signed [COS_W-1:0] max_cosine;
	logic [PAIR_W-1:0] pair_count;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = REG_MAX_COS_THR;
	logic [COS_W-1:0] cfg_data = '0;

	polyline_straightness_check_unit #(
		.COORD_WIDTH(CW),
		.FRAC_BITS(FB),
		.MAX_CHAIN(CHAIN_LIMIT)
	) DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.start_x(start_x), .start_y(start_y), .start_z(start_z),
		.end_x(end_x), .end_y(end_y), .end_z(end_z), .last_edge(last_edge),
		.out_valid(out_valid), .out_ready(out_ready),
		.is_distorted(is_distorted), .max_cosine(max_cosine), .pair_count(pair_count),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Pending edges, expected chain verdicts and error bookkeeping
	edge_item_t edge_q[$];
	chain_verdict_t verdict_q[$];
	int mismatches = 0;
	int edges_taken = 0;
	bit gaps_on = 1'b1;

	// Shadow registers and chain state of the straightness predictor
	logic signed [COS_W-1:0] thr_max_cos = MAX_COS_THR_RST;
	logic signed [COS_W-1:0] thr_avg_cos = AVG_COS_THR_RST;
	logic [MIN_LEN_W-1:0] min_len = MIN_EDGE_LEN_RST;
	longint prev_vx = 0, prev_vy = 0, prev_vz = 0;
	bit have_prev = 1'b0;
	logic signed [COS_W-1:0] run_max = COS_MIN;
	longint run_sum = 0;
	int pairs_counted = 0;

	// Bit-by-bit integer square root, floor
	function automatic longint unsigned sqrt_floor(longint unsigned v);
		longint unsigned res, pw;
		res = 0;
		pw = 64'd1 << 62;
		while (pw > v)
			pw = pw >> 2;
		while (pw != 0) begin
			if (v >= res + pw) begin
				v = v - (res + pw);
				res = (res >> 1) + pw;
			end else begin
				res = res >> 1;
			end
			pw = pw >> 2;
		end
		return res;
	endfunction

	// Short edges count as unit length
	function automatic longint unsigned edge_length(longint x, longint y, longint z);
		longint unsigned len;
		len = sqrt_floor(longint'(x * x) + longint'(y * y) + longint'(z * z));
		if (len < min_len)
			len = 64'd1 << FB;
		return len;
	endfunction

	function automatic logic signed [COS_W-1:0] pair_cosine(longint ax, longint ay, longint az,
			longint bx, longint by, longint bz);
		longint dot;
		longint unsigned den, mag, q, r, f, rnd;
		dot = ax * bx + ay * by + az * bz;
		den = edge_length(ax, ay, az) * edge_length(bx, by, bz);
		if (den == 0)
			return '0;
		mag = (dot < 0) ? -dot : dot;
		q = mag / den;
		r = mag % den;
		if (q > 1)
			q = 2;
		f = 0;
		for (int i = 0; i < DIV_STEPS; i++) begin
			r = r << 1;
			f = f << 1;
			if (r >= den) begin
				r = r - den;
				f = f | 1;
			end
		end
		rnd = ((q << 16) + f + 1) >> 1;
		if (dot >= 0)
			return (rnd > 32767) ? COS_MAX : COS_W'(rnd);
		return (rnd > 32768) ? COS_MIN : COS_W'(64'd0 - rnd);
	endfunction

	// Advance the chain state by one accepted edge; queue a verdict on the last edge
	function automatic void account_edge(edge_item_t e);
		longint vx, vy, vz;
		logic signed [COS_W-1:0] c;
		chain_verdict_t v;
		vx = longint'(e.ex) - longint'(e.sx);
		vy = longint'(e.ey) - longint'(e.sy);
		vz = longint'(e.ez) - longint'(e.sz);
		if (have_prev) begin
			c = pair_cosine(prev_vx, prev_vy, prev_vz, vx, vy, vz);
			if (c > run_max)
				run_max = c;
			if (pairs_counted < CHAIN_LIMIT - 1) begin
				run_sum += longint'(c);
				pairs_counted++;
			end
		end
		prev_vx = vx;
		prev_vy = vy;
		prev_vz = vz;
		have_prev = 1'b1;
		if (e.last) begin
			v.distorted = (pairs_counted > 0) && (run_max < thr_max_cos ||
				run_sum < longint'(thr_avg_cos) * pairs_counted);
			v.max_cos = run_max;
			v.pairs = PAIR_W'(pairs_counted);
			verdict_q = {verdict_q, v};
			have_prev = 1'b0;
			prev_vx = 0;
			prev_vy = 0;
			prev_vz = 0;
			run_max = COS_MIN;
			run_sum = 0;
			pairs_counted = 0;
		end
	endfunction

	// Mostly back-to-back, sometimes short gaps, rarely long ones
	function automatic int pick_gap();
		int r;
		if (!gaps_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic int signed_rand(int amp);
		return int'($urandom_range(0, 2 * amp)) - amp;
	endfunction

	// Edge driver: hold the payload until the transaction completes
	int send_idle = 0;
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				account_edge(edge_q.pop_front());
				edges_taken++;
				send_idle = pick_gap();
			end
			if (in_valid && !in_ready) begin
				// hold
			end else if (send_idle > 0) begin
				send_idle--;
				in_valid <= 1'b0;
			end else if (edge_q.size() > 0) begin
				start_x <= edge_q[0].sx;
				start_y <= edge_q[0].sy;
				start_z <= edge_q[0].sz;
				end_x <= edge_q[0].ex;
				end_y <= edge_q[0].ey;
				end_z <= edge_q[0].ez;
				last_edge <= edge_q[0].last;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result monitor with random back-pressure and one long hold-off
	int hold_left = 0;
	bit pressure_done = 1'b0;
	always @(posedge clk) begin
		chain_verdict_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (verdict_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected chain result: dist=%0b max=%0d pairs=%0d",
							is_distorted, max_cosine, pair_count);
				end else begin
					want = verdict_q.pop_front();
					if (is_distorted !== want.distorted || max_cosine !== want.max_cos ||
							pair_count !== want.pairs) begin
						mismatches++;
						if (mismatches <= 10)
							$display("chain result mismatch: exp dist=%0b max=%0d pairs=%0d,",
								want.distorted, want.max_cos, want.pairs,
								" got dist=%0b max=%0d pairs=%0d",
								is_distorted, max_cosine, pair_count);
					end
				end
			end
			if (!pressure_done && edges_taken >= 200) begin
				pressure_done = 1'b1;
				hold_left = 600;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= (pick_gap() == 0);
			end
		end
	end

	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [COS_W-1:0] data);
		@(posedge clk);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_MAX_COS_THR: thr_max_cos = data;
			REG_AVG_COS_THR: thr_avg_cos = data;
			REG_MIN_EDGE_LEN: min_len = data[MIN_LEN_W-1:0];
			default: ;
		endcase
	endtask

	task automatic push_edge(int sx, int sy, int sz, int ex, int ey, int ez, bit last);
		edge_item_t e;
		e.sx = CW'(sx); e.sy = CW'(sy); e.sz = CW'(sz);
		e.ex = CW'(ex); e.ey = CW'(ey); e.ez = CW'(ez);
		e.last = last;
		edge_q = {edge_q, e};
	endtask

	// Chain styles: 0 straight, 1 gentle wobble, 2 bendy, 3 arbitrary coordinates
	task automatic add_chain(int n, int style);
		int dx, dy, dz, px, py, pz, nx, ny, nz, amp;
		dx = signed_rand(1 << 16);
		dy = signed_rand(1 << 16);
		dz = signed_rand(1 << 16);
		amp = (style == 0) ? 0 : (style == 1) ? 2048 : (1 << 16);
		for (int i = 0; i < n; i++) begin
			if (style == 3) begin
				push_edge($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
					i == n - 1);
			end else begin
				px = signed_rand(1 << 21);
				py = signed_rand(1 << 21);
				pz = signed_rand(1 << 21);
				nx = signed_rand(amp);
				ny = signed_rand(amp);
				nz = signed_rand(amp);
				// drop in an occasional degenerate edge
				if ($urandom_range(0, 99) < 3)
					push_edge(px, py, pz, px, py, pz, i == n - 1);
				else
					push_edge(px, py, pz, px + dx + nx, py + dy + ny, pz + dz + nz,
						i == n - 1);
			end
		end
	endtask

	task automatic add_random_chains(int edge_budget);
		int n, used;
		used = 0;
		while (used < edge_budget) begin
			case ($urandom_range(0, 9))
				0: n = 1;
				1, 2: n = $urandom_range(9, 30);
				default: n = $urandom_range(2, 8);
			endcase
			add_chain(n, $urandom_range(0, 3));
			used += n;
		end
	endtask

	// Wait until every queued edge is taken and every verdict has come back
	task automatic drain();
		wait (edge_q.size() == 0 && !in_valid);
		while (verdict_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: single edge chain
		push_edge(0, 0, 0, 4096, 0, 0, 1);
		// Extreme coordinates, then the exact reverse edge
		push_edge(-8388608, -8388608, -8388608, 8388607, 8388607, 8388607, 0);
		push_edge(8388607, 8388607, 8388607, -8388608, -8388608, -8388608, 1);
		// Zero-length edge taken as unit length, then an ordinary one
		push_edge(100, 200, 300, 100, 200, 300, 0);
		push_edge(0, 0, 0, 0, 8192, 0, 1);
		// Straight run
		for (int i = 0; i < 4; i++)
			push_edge(i * 4096, 0, 0, (i + 1) * 4096, 4096, 0, i == 3);
		// Right-angle zigzag
		push_edge(0, 0, 0, 4096, 0, 0, 0);
		push_edge(0, 0, 0, 0, 4096, 0, 0);
		push_edge(0, 0, 0, 0, 0, 4096, 0);
		push_edge(0, 0, 0, -4096, 0, 0, 1);
		drain();

		// No length floor: zero-length pairs give a zero cosine
		write_register(REG_MIN_EDGE_LEN, '0);
		write_register(REG_MAX_COS_THR, COS_MIN);
		write_register(REG_AVG_COS_THR, COS_MIN);
		push_edge(5, 5, 5, 5, 5, 5, 0);
		push_edge(7, 7, 7, 7, 7, 7, 0);
		push_edge(0, 0, 0, 1, 0, 0, 1);
		add_random_chains(200);
		drain();

		// Strictest bounds and the largest length floor
		write_register(REG_MAX_COS_THR, COS_MAX);
		write_register(REG_AVG_COS_THR, COS_MAX);
		write_register(REG_MIN_EDGE_LEN, 16'(4095));
		gaps_on = 1'b0;
		add_random_chains(170);
		drain();

		// Defaults again, with a chain long enough to saturate the pair count
		write_register(REG_MAX_COS_THR, MAX_COS_THR_RST);
		write_register(REG_AVG_COS_THR, AVG_COS_THR_RST);
		write_register(REG_MIN_EDGE_LEN, 16'(MIN_EDGE_LEN_RST));
		gaps_on = 1'b1;
		add_chain(1030, 1);
		add_random_chains(40);
		drain();

		// Random register settings
		write_register(REG_MAX_COS_THR, 16'($urandom_range(20000, 32767)));
		write_register(REG_AVG_COS_THR, 16'($urandom_range(24000, 32767)));
		write_register(REG_MIN_EDGE_LEN, 16'($urandom_range(0, 4095)));
		add_random_chains(170);
		drain();

		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/psc_pkg.sv
hw/rtl/psc_mul.sv
hw/rtl/psc_sqrt.sv
hw/rtl/polyline_straightness_check_unit.sv
tb/polyline_straightness_check_unit_tb.sv
